// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/clne_pkg.sv -----
`timescale 1ns / 1ps

package clne_pkg;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_CURSOR = 2'd2;
  localparam logic [1:0] REQ_INIT   = 2'd3;

  // Three expander bytes per nibble: setup, enable high, enable low.
  localparam logic [1:0] PH_SETUP  = 2'd0;
  localparam logic [1:0] PH_STROBE = 2'd1;
  localparam logic [1:0] PH_HOLD   = 2'd2;

  // Nibble counter: a byte has two nibbles, the init sequence fourteen.
  localparam int unsigned NIB_IDX_W = 4;
  localparam logic [NIB_IDX_W-1:0] BYTE_LAST_NIB = 4'd1;
  localparam logic [NIB_IDX_W-1:0] INIT_LAST_NIB = 4'd13;

  localparam logic [7:0] SET_DDRAM_CMD = 8'h80;

  // Per-beat control from the sequencer to the byte builder.
  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
    logic       rs;
    logic [1:0] phase;
    logic       last;
  } nib_ctl_t;

  // DDRAM start address of each display row.
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

  // Nibbles of the power-up sequence: four single nibbles, then the
  // commands 0x28, 0x08, 0x01, 0x06, 0x0C as high and low nibbles.
  function automatic logic [3:0] init_nibble(input logic [NIB_IDX_W-1:0] idx);
    logic [3:0] nib;
    unique case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3:             nib = 4'h2;
      4'd4:             nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd6:             nib = 4'h0;
      4'd7:             nib = 4'h8;
      4'd8:             nib = 4'h0;
      4'd9:             nib = 4'h1;
      4'd10:            nib = 4'h0;
      4'd11:            nib = 4'h6;
      4'd12:            nib = 4'h0;
      4'd13:            nib = 4'hC;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

// ----- rtl/char_lcd_nibble_expander_encoder_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit first)                         tuser / tlast
// in_*      slave      value[7:0], cursor_col[13:8], cursor_row[15:14] tuser = req_type
// out_*     master     expander_byte[7:0]                              tlast = last
// cfg_*     write      cfg_wr_data = backlight_on                      -
//
// A command, data or set-cursor request is accepted, then sent as six output
// beats; an init request is sent as 42 beats. The nibble sequencer issues
// one expander byte per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties the output and turns the backlight on.
// A stalled output holds the sequencer; the input is not ready during a request.

module char_lcd_nibble_expander_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // value[7:0], cursor_col[13:8], cursor_row[15:14]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // expander_byte[7:0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  clne_pkg::nib_ctl_t ctl;
  logic               step;
  logic               backlight_r;

  // Backlight configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b1;
    end else if (cfg_wr_en) begin
      backlight_r <= cfg_wr_data;
    end
  end

  clne_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .step      (step),
    .ctl       (ctl)
  );

  clne_fmt u_fmt (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .backlight_on (backlight_r),
    .step         (step),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

// ----- rtl/clne_seq.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clne_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                step,
  output clne_pkg::nib_ctl_t  ctl
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t                             state_r, state_nxt;
  logic [7:0]                         byte_r, byte_nxt;
  logic                               rs_r, rs_nxt;
  logic                               init_r, init_nxt;
  logic [clne_pkg::NIB_IDX_W-1:0]     nib_r, nib_nxt;
  logic [1:0]                         phase_r, phase_nxt;

  logic [7:0]                         req_value;
  logic [7:0]                         req_col;
  logic [1:0]                         req_row;
  logic [7:0]                         cursor_cmd;
  logic [clne_pkg::NIB_IDX_W-1:0]     last_nib;
  logic                               in_fire;

  // Unpack the input beat.
  assign req_value = in_tdata[7:0];
  assign req_col   = {2'b00, in_tdata[13:8]};
  assign req_row   = in_tdata[15:14];

  // Set-cursor command: column plus row base, wrapping at 256.
  assign cursor_cmd = clne_pkg::SET_DDRAM_CMD | (req_col + clne_pkg::row_base(req_row));

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign last_nib  = init_r ? clne_pkg::INIT_LAST_NIB : clne_pkg::BYTE_LAST_NIB;

  // Current beat description for the byte builder.
  always_comb begin
    ctl.valid  = (state_r == S_RUN);
    ctl.nibble = init_r ? clne_pkg::init_nibble(nib_r)
                        : (nib_r[0] ? byte_r[3:0] : byte_r[7:4]);
    ctl.rs     = rs_r;
    ctl.phase  = phase_r;
    ctl.last   = (phase_r == clne_pkg::PH_HOLD) && (nib_r == last_nib);
  end

  // Sequencer next state: load on accept, then step phase and nibble.
  always_comb begin
    state_nxt = state_r;
    byte_nxt  = byte_r;
    rs_nxt    = rs_r;
    init_nxt  = init_r;
    nib_nxt   = nib_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_RUN;
          nib_nxt   = '0;
          phase_nxt = clne_pkg::PH_SETUP;
          rs_nxt    = (in_tuser == clne_pkg::REQ_DATA);
          init_nxt  = (in_tuser == clne_pkg::REQ_INIT);
          case (in_tuser)
            clne_pkg::REQ_CURSOR: byte_nxt = cursor_cmd;
            default:              byte_nxt = req_value;
          endcase
        end
      end
      S_RUN: begin
        if (step) begin
          if (phase_r == clne_pkg::PH_HOLD) begin
            phase_nxt = clne_pkg::PH_SETUP;
            if (nib_r == last_nib) begin
              state_nxt = S_IDLE;
            end else begin
              nib_nxt = nib_r + 1'b1;
            end
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nib_r   <= '0;
      phase_r <= clne_pkg::PH_SETUP;
      init_r  <= 1'b0;
      rs_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nib_r   <= nib_nxt;
      phase_r <= phase_nxt;
      init_r  <= init_nxt;
      rs_r    <= rs_nxt;
    end
  end

  // Command byte needs no reset.
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // The final beat of a request frees the input side next cycle.
  `ASSERT_NEXT(a_last_frees_input, clk, rst_n, step && ctl.last, in_tready)
  // The nibble counter never passes the end of the init sequence.
  `ASSERT_SAME(a_nib_in_range, clk, rst_n, 1'b1, nib_r <= clne_pkg::INIT_LAST_NIB)
  // A byte request never counts beyond its second nibble.
  `ASSERT_SAME(a_byte_two_nibbles, clk, rst_n, !init_r, nib_r <= clne_pkg::BYTE_LAST_NIB)

endmodule

// ----- rtl/clne_fmt.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clne_fmt (
  input  logic                clk,
  input  logic                rst_n,
  input  clne_pkg::nib_ctl_t  ctl,
  input  logic                backlight_on,
  output logic                step,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic [7:0] exp_byte;

  // Expander byte: nibble, backlight, enable, unused, register select.
  assign exp_byte = {ctl.nibble, backlight_on, (ctl.phase == clne_pkg::PH_STROBE),
                     1'b0, ctl.rs};

  // A beat moves into the output register when it is empty or being taken.
  assign step = ctl.valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (step) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (step) begin
      out_tdata_r <= exp_byte;
      out_tlast_r <= ctl.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // The last byte of a request always has enable low.
  `ASSERT_SAME(a_last_enable_low, clk, rst_n, out_tvalid && out_tlast, !out_tdata[2])
  // A strobe beat shows up with enable high on the output.
  `ASSERT_NEXT(a_strobe_enable, clk, rst_n, step && (ctl.phase == clne_pkg::PH_STROBE),
               out_tvalid && out_tdata[2])

endmodule
